// ===== rtl/pev_pkg.sv =====
`timescale 1ns / 1ps

package pev_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int WORD_BITS   = 32;
  localparam int VALUE_BITS  = 32;
  localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
  localparam int MEM_DEPTH   = 2 ** ADDR_BITS;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ADD,
    OP_MUL
  } pev_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_EMPTY = 2'd3
  } pev_status_e;

  typedef struct packed {
    logic    push_en;
    word_t   push_val;
    pev_op_e op;
    logic    last;
  } pev_cmd_t;

  function automatic logic [VALUE_BITS-1:0] to_value(input word_t w);
    logic signed [WORD_BITS-1:0] sw;
    sw = signed'(w);
    return VALUE_BITS'(sw);
  endfunction

endpackage

// ===== rtl/pev_front.sv =====
`timescale 1ns / 1ps

module pev_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        char_code_i,
  input  logic              is_last_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output pev_pkg::pev_cmd_t q_cmd_o
);
  import pev_pkg::*;

  word_t   acc_q, acc_d, acc_next, digit;
  logic    in_num_q, in_num_d;
  logic    is_digit, accept, need;
  pev_op_e op;

  always_comb begin
    is_digit = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
    digit    = WORD_BITS'(char_code_i - CH_ZERO);
    acc_next = (acc_q << 3) + (acc_q << 1) + digit;
    case (char_code_i)
      CH_PLUS: op = OP_ADD;
      CH_STAR: op = OP_MUL;
      default: op = OP_NONE;
    endcase

    q_cmd_o.push_en  = is_digit ? is_last_i : in_num_q;
    q_cmd_o.push_val = is_digit ? acc_next : acc_q;
    q_cmd_o.op       = op;
    q_cmd_o.last     = is_last_i;

    need       = q_cmd_o.push_en || (op != OP_NONE) || is_last_i;
    in_stall_o = q_full_i;
    accept     = in_valid_i && !q_full_i;
    q_push_o   = accept && need;

    acc_d    = acc_q;
    in_num_d = in_num_q;
    if (accept) begin
      if (is_last_i || !is_digit) begin
        acc_d    = '0;
        in_num_d = 1'b0;
      end else begin
        acc_d    = acc_next;
        in_num_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      in_num_q <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      in_num_q <= in_num_d;
    end
  end

endmodule

// ===== rtl/pev_queue.sv =====
`timescale 1ns / 1ps

module pev_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pev_pkg::pev_cmd_t push_cmd_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output pev_pkg::pev_cmd_t pop_cmd_o
);
  import pev_pkg::*;

  pev_cmd_t               slot_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_BITS-1:0]   cnt_q, cnt_d;
  logic                   do_push, do_pop;

  always_comb begin
    full_o    = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
    valid_o   = (cnt_q != '0);
    pop_cmd_o = slot_q[rd_q];
    do_push   = push_i && !full_o;
    do_pop    = pop_i && valid_o;
    wr_d      = do_push ? wr_q + 1'b1 : wr_q;
    rd_d      = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d     = cnt_q + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count out of range");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not advance on push");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty queue with pointers apart");
`endif

endmodule

// ===== rtl/pev_back.sv =====
`timescale 1ns / 1ps

module pev_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  pev_pkg::pev_cmd_t              cmd_i,
  output logic                           cmd_take_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pev_pkg::VALUE_BITS-1:0] value_o,
  output logic [1:0]                     status_o
);
  import pev_pkg::*;

  word_t                  mem [MEM_DEPTH];
  word_t                  top_q, top_d, sec_q, sec_d, below_q;
  word_t                  opa, opb, alu;
  logic [CNT_BITS-1:0]    cnt_q, cnt_d, cnt_n;
  pev_status_e            err_q, err_d, err_n, fin_st;
  logic                   wr_en;
  logic [ADDR_BITS-1:0]   wr_addr, rd_addr;
  logic                   out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0]  value_q, value_d;
  pev_status_e            status_q, status_d;
  logic                   out_free, finish;

  always_comb begin
    out_free   = !out_valid_q || !out_stall_i;
    cmd_take_o = cmd_valid_i && (!cmd_i.last || out_free);
    finish     = cmd_take_o && cmd_i.last;

    opa = cmd_i.push_en ? top_q : sec_q;
    opb = cmd_i.push_en ? cmd_i.push_val : top_q;
    case (cmd_i.op)
      OP_MUL:  alu = opa * opb;
      default: alu = opa + opb;
    endcase

    cnt_n   = cnt_q;
    err_n   = err_q;
    top_d   = top_q;
    sec_d   = sec_q;
    wr_en   = 1'b0;
    wr_addr = ADDR_BITS'(cnt_q - CNT_BITS'(2));

    if (cmd_take_o && (err_q == ST_OK)) begin
      if (cmd_i.push_en && (cnt_q == CNT_BITS'(STACK_DEPTH))) begin
        err_n = ST_OVER;
      end else if (cmd_i.push_en && (cmd_i.op != OP_NONE)) begin
        if (cnt_q == '0) begin
          err_n = ST_UNDER;
        end else begin
          top_d = alu;
        end
      end else if (cmd_i.push_en) begin
        wr_en = (cnt_q >= CNT_BITS'(2));
        sec_d = top_q;
        top_d = cmd_i.push_val;
        cnt_n = cnt_q + 1'b1;
      end else if (cmd_i.op != OP_NONE) begin
        if (cnt_q < CNT_BITS'(2)) begin
          err_n = ST_UNDER;
        end else begin
          top_d = alu;
          sec_d = below_q;
          cnt_n = cnt_q - 1'b1;
        end
      end
    end

    rd_addr = ADDR_BITS'(cnt_n - CNT_BITS'(3));

    if (err_n != ST_OK) begin
      fin_st = err_n;
    end else if (cnt_n == '0) begin
      fin_st = ST_EMPTY;
    end else begin
      fin_st = ST_OK;
    end

    cnt_d       = finish ? '0 : cnt_n;
    err_d       = finish ? ST_OK : err_n;
    out_valid_d = finish ? 1'b1 : (out_valid_q && out_stall_i);
    value_d     = value_q;
    status_d    = status_q;
    if (finish) begin
      status_d = fin_st;
      value_d  = (fin_st == ST_OK) ? to_value(top_d) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    sec_q    <= sec_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= sec_q;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      below_q <= sec_q;
    end else begin
      below_q <= mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(STACK_DEPTH))
    else $error("stack count beyond depth");
  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (cnt_q == '0) && (err_q == ST_OK) && out_valid_q)
    else $error("state not cleared after final request");
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(finish))
    else $error("result raised without final request");
  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != ST_OK)) |-> (value_q == '0))
    else $error("nonzero value with error status");
`endif

endmodule

// ===== rtl/postfix_expression_evaluator.sv =====
`timescale 1ns / 1ps

// Postfix expression evaluator.
// Input channel: in_valid_i / in_stall_o with char_code_i and is_last_i, one
// ASCII character per request. Digits build a decimal number; '+' and '*'
// pop two operands and push the wrapped sum or product; other characters
// separate. is_last_i closes the expression.
// Output channel: out_valid_o / out_stall_i with value_o and status_o, one
// request per expression (0 ok, 1 underflow, 2 overflow, 3 empty stack).
// Throughput: one character per cycle while the command queue is not full. The
// front classifies each character in its accept cycle; the back executes one
// queued command per cycle unless a final command waits on a stalled result,
// with the top two stack words in registers and the rest in a memory whose
// registered read keeps the third word ready. A last character is queued,
// then the back takes it and registers the result and out_valid_o.
// Stall: a stalled result holds; the back keeps working on non-final commands,
// and the input stalls only when the four-entry command queue fills.
// Reset: clears the queue, stack count, error and output valid; the block
// accepts characters as soon as reset is released.

module postfix_expression_evaluator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     char_code_i,
  input  logic                           is_last_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pev_pkg::VALUE_BITS-1:0] value_o,
  output logic [1:0]                     status_o
);
  import pev_pkg::*;

  pev_cmd_t push_cmd, pop_cmd;
  logic     q_push, q_full, q_valid, q_pop;

  pev_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .char_code_i(char_code_i),
    .is_last_i  (is_last_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  pev_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_cmd_i(push_cmd),
    .full_o    (q_full),
    .valid_o   (q_valid),
    .pop_i     (q_pop),
    .pop_cmd_o (pop_cmd)
  );

  pev_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (pop_cmd),
    .cmd_take_o (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_o    (value_o),
    .status_o   (status_o)
  );

endmodule
